// File: design/exponential_search_table_unit_defines.svh
// Assertion macros used by the checker file of the exponential search table.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef EXPONENTIAL_SEARCH_TABLE_UNIT_DEFINES_SVH
`define EXPONENTIAL_SEARCH_TABLE_UNIT_DEFINES_SVH

// Check on every rising edge outside reset.
`define EST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising edge, reset included.
`define EST_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/est_pkg.sv
// Package of the exponential search table: item types, status codes, defaults.
// No dependencies; used by every module of the block.
`default_nettype none

package est_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 1024;
  localparam int unsigned DEF_KEY_WIDTH   = 32;

  localparam int unsigned IN_IDX_W   = 10;
  localparam int unsigned IN_KEY_W   = 32;
  localparam int unsigned OUT_IDX_W  = 10;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_COMPARE = 1'b1;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2
  } est_status_e;

  typedef struct packed {
    logic                req_type;
    logic [IN_IDX_W-1:0] entry_index;
    logic [IN_KEY_W-1:0] entry_value;
    logic [IN_KEY_W-1:0] search_key;
  } est_in_t;

  typedef struct packed {
    est_status_e          status;
    logic [OUT_IDX_W-1:0] found_index;
  } est_out_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } est_cmp_t;

endpackage

`default_nettype wire

// File: design/est_key_store.sv
// Key table memory with a registered read port and the ordered key compare.
// Depends on est_pkg for the compare result type.
`default_nettype none

module est_key_store #(
  parameter int unsigned TABLE_DEPTH = est_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned KEY_WIDTH   = est_pkg::DEF_KEY_WIDTH,
  parameter int unsigned ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  wire logic                 clk_i,
  input  wire logic                 wr_en_i,
  input  wire logic [ADDR_W-1:0]    wr_addr_i,
  input  wire logic [KEY_WIDTH-1:0] wr_key_i,
  input  wire logic                 rd_en_i,
  input  wire logic [ADDR_W-1:0]    rd_addr_i,
  input  wire logic [KEY_WIDTH-1:0] key_i,
  input  wire logic                 signed_i,
  output est_pkg::est_cmp_t         cmp_o
);
  import est_pkg::*;

  logic [KEY_WIDTH-1:0] mem_q [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] rd_data_q;
  logic [KEY_WIDTH-1:0] sign_mask;
  logic [KEY_WIDTH-1:0] elem_ord;
  logic [KEY_WIDTH-1:0] key_ord;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_key_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // flip the sign bit to map two's complement order onto unsigned order
  always_comb begin
    sign_mask = signed_i ? (KEY_WIDTH'(1) << (KEY_WIDTH - 1)) : '0;
    elem_ord  = rd_data_q ^ sign_mask;
    key_ord   = key_i ^ sign_mask;
    cmp_o.eq  = (elem_ord == key_ord);
    cmp_o.lt  = (elem_ord < key_ord);
  end

endmodule

`default_nettype wire

// File: design/exponential_search_table_unit.sv
// Top level of the exponential search table: request control and result register.
// Depends on est_pkg and est_key_store.
//
//   channel   direction  handshake                payload
//   in        input      in_valid_i / in_ready_o  in_data_i  (est_in_t)
//   out       output     out_valid_o / out_ready_i out_data_o (est_out_t)
//   cfg       input      cfg_we_i                 cfg_index_i, cfg_data_i
//
// One item at a time. A write or an empty search goes through S_DONE to the output register.
// A search makes one key table read and compare per exponential probe, then after S_BRK
// a read state (S_BIN_RD) and a compare state (S_BIN_CMP) per binary step.
// Reset clears control and configuration; the key table has no clearing pass.
// A stalled result holds in the output register while the next item is accepted.
`default_nettype none

module exponential_search_table_unit #(
  parameter int unsigned TABLE_DEPTH = est_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned KEY_WIDTH   = est_pkg::DEF_KEY_WIDTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  est_pkg::est_in_t                        in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output est_pkg::est_out_t                       out_data_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [est_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [est_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import est_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXP     = 3'd1;
  localparam logic [2:0] S_BRK     = 3'd2;
  localparam logic [2:0] S_BIN_RD  = 3'd3;
  localparam logic [2:0] S_BIN_CMP = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]           state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  est_out_t             out_q, out_d;
  est_out_t             res_q, res_d;
  logic [COUNT_W-1:0]   entry_count_q;
  logic                 signed_q;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [CW-1:0]        n_q, n_d;
  logic [CW-1:0]        lo_q, lo_d;
  logic [CW-1:0]        hi_q, hi_d;
  logic [CW-1:0]        blo_q, blo_d;
  logic [CW-1:0]        bend_q, bend_d;
  logic [CW-1:0]        mid_q, mid_d;
  logic [CW-1:0]        n_eff;
  logic [CW-1:0]        next_hi;
  logic [CW-1:0]        hi_bound;
  logic [CW-1:0]        mid;
  logic                 in_acc;
  logic                 out_free;
  logic                 wr_en;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  est_cmp_t             cmp;

  est_key_store #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH),
    .ADDR_W     (AW)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(AW'(in_data_i.entry_index)),
    .wr_key_i (KEY_WIDTH'(in_data_i.entry_value)),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .key_i    (key_q),
    .signed_i (signed_q),
    .cmp_o    (cmp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      signed_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ENTRY_COUNT:    entry_count_q <= cfg_data_i;
        CFG_SIGNED_COMPARE: signed_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(entry_count_q) >= TABLE_DEPTH) begin
      n_eff = CW'(TABLE_DEPTH);
    end else begin
      n_eff = CW'(entry_count_q);
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign next_hi = (hi_q == '0) ? CW'(1) : (hi_q << 1);
  assign mid     = blo_q + ((bend_q - CW'(1) - blo_q) >> 1);

  always_comb begin
    if (hi_q >= n_q) begin
      hi_bound = n_q - CW'(1);
    end else begin
      hi_bound = hi_q;
    end
    if (hi_bound < lo_q) begin
      hi_bound = lo_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    res_d       = res_q;
    key_d       = key_q;
    n_d         = n_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    blo_d       = blo_q;
    bend_d      = bend_q;
    mid_d       = mid_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_d.found_index = '0;
          if (in_data_i.req_type == REQ_WRITE) begin
            wr_en        = (32'(in_data_i.entry_index) < TABLE_DEPTH);
            res_d.status = ST_OK;
            state_d      = S_DONE;
          end else begin
            key_d = KEY_WIDTH'(in_data_i.search_key);
            n_d   = n_eff;
            if (n_eff == '0) begin
              res_d.status = ST_EMPTY;
              state_d      = S_DONE;
            end else begin
              rd_en   = 1'b1;
              lo_d    = '0;
              hi_d    = '0;
              state_d = S_EXP;
            end
          end
        end
      end
      S_EXP: begin
        if (cmp.eq) begin
          res_d.status      = ST_OK;
          res_d.found_index = OUT_IDX_W'(hi_q);
          state_d           = S_DONE;
        end else if (hi_q == '0 || cmp.lt) begin
          lo_d = hi_q;
          hi_d = next_hi;
          if (next_hi < n_q) begin
            rd_en   = 1'b1;
            rd_addr = AW'(next_hi);
          end else begin
            state_d = S_BRK;
          end
        end else begin
          state_d = S_BRK;
        end
      end
      S_BRK: begin
        blo_d   = lo_q;
        bend_d  = hi_bound + CW'(1);
        state_d = S_BIN_RD;
      end
      S_BIN_RD: begin
        if (blo_q < bend_q) begin
          rd_en   = 1'b1;
          rd_addr = AW'(mid);
          mid_d   = mid;
          state_d = S_BIN_CMP;
        end else begin
          res_d.status      = ST_NOT_FOUND;
          res_d.found_index = '0;
          state_d           = S_DONE;
        end
      end
      S_BIN_CMP: begin
        if (cmp.eq) begin
          res_d.status      = ST_OK;
          res_d.found_index = OUT_IDX_W'(mid_q);
          state_d           = S_DONE;
        end else begin
          if (cmp.lt) begin
            blo_d = mid_q + CW'(1);
          end else begin
            bend_d = mid_q;
          end
          state_d = S_BIN_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    res_q  <= res_d;
    key_q  <= key_d;
    n_q    <= n_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    blo_q  <= blo_d;
    bend_q <= bend_d;
    mid_q  <= mid_d;
  end

endmodule

`default_nettype wire

// File: design/est_sva_checker.sv
// Port-level checker for the exponential search table, bound to the top level.
// Depends on est_pkg and exponential_search_table_unit_defines.svh.
`default_nettype none
`include "exponential_search_table_unit_defines.svh"

module est_sva_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input est_pkg::est_in_t                    in_data_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input est_pkg::est_out_t                   out_data_o,
  input wire logic                           cfg_we_i,
  input wire logic [est_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [est_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import est_pkg::*;

  `EST_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result item dropped")
  `EST_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_data_o), "result item changed")
  `EST_ASSERT(a_one_item, in_valid_i && in_ready_o |=> !in_ready_o, "second item taken while busy")
  `EST_ASSERT(a_idx_zero, out_valid_o && out_data_o.status != ST_OK |-> out_data_o.found_index == '0, "index set on a miss")
  `EST_ASSERT_RST(a_rst_out, !rst_ni |-> !out_valid_o, "result offered in reset")

endmodule

bind exponential_search_table_unit est_sva_checker u_est_sva_checker (.*);

`default_nettype wire
